// ===== design/bbc_pkg.sv =====
package bbc_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 64;

	localparam logic [7:0] CHR_LPAREN = 8'h28;
	localparam logic [7:0] CHR_RPAREN = 8'h29;
	localparam logic [7:0] CHR_LSQUARE = 8'h5B;
	localparam logic [7:0] CHR_RSQUARE = 8'h5D;
	localparam logic [7:0] CHR_LCURLY = 8'h7B;
	localparam logic [7:0] CHR_RCURLY = 8'h7D;

	typedef enum logic [1:0] {
		CODE_PAREN  = 2'd0,
		CODE_SQUARE = 2'd1,
		CODE_CURLY  = 2'd2
	} code_t;

	typedef struct packed {
		logic  push;
		logic  pop;
		logic  clear;
		code_t code;
	} stack_cmd_t;

	typedef struct packed {
		logic  empty;
		logic  single;
		logic  full;
		code_t top;
	} stack_stat_t;

	typedef struct packed {
		logic  hit;
		code_t code;
	} bracket_t;

	function automatic bracket_t decode_open(input logic [7:0] c);
		bracket_t r;
		r.hit  = 1'b1;
		r.code = CODE_PAREN;
		unique case (c)
			CHR_LPAREN:  r.code = CODE_PAREN;
			CHR_LSQUARE: r.code = CODE_SQUARE;
			CHR_LCURLY:  r.code = CODE_CURLY;
			default:     r.hit  = 1'b0;
		endcase
		return r;
	endfunction

	function automatic bracket_t decode_close(input logic [7:0] c);
		bracket_t r;
		r.hit  = 1'b1;
		r.code = CODE_PAREN;
		unique case (c)
			CHR_RPAREN:  r.code = CODE_PAREN;
			CHR_RSQUARE: r.code = CODE_SQUARE;
			CHR_RCURLY:  r.code = CODE_CURLY;
			default:     r.hit  = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/bbc_stack.sv =====
module bbc_stack #(
	parameter int unsigned DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bbc_pkg::stack_cmd_t cmd,
	output bbc_pkg::stack_stat_t stat
);
	import bbc_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned AW = $clog2(DEPTH);

	code_t          mem [DEPTH];
	code_t          top_q;
	code_t          rd_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  count_n;
	logic [CW-1:0]  below_n;
	logic [AW-1:0]  rd_addr;
	logic [AW-1:0]  wr_addr;

	always_comb begin
		if (cmd.clear) begin
			count_n = '0;
		end else if (cmd.push) begin
			count_n = count_q + CW'(1);
		end else if (cmd.pop) begin
			count_n = count_q - CW'(1);
		end else begin
			count_n = count_q;
		end
	end

	// prefetch the entry under the next top
	assign below_n = count_n - CW'(2);
	assign rd_addr = below_n[AW-1:0];
	assign wr_addr = count_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wr_addr] <= cmd.code;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			top_q <= cmd.code;
		end else if (cmd.pop) begin
			top_q <= rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_n;
		end
	end

	assign stat.empty  = (count_q == '0);
	assign stat.single = (count_q == CW'(1));
	assign stat.full   = (count_q == CW'(DEPTH));
	assign stat.top    = top_q;

endmodule

// ===== design/bracket_balance_checker.sv =====
// Result: registered; it appears in the cycle after the final input word is taken.
// Throughput: one input word per cycle while no held result stalls s_axis_tready;
// the stack memory's registered read port prefetches the entry under the top.
// Reset: arst_n clears the stack count, the error and overflow flags and the
// output valid; stack memory stays undefined, and unwritten entries go unused.
module bracket_balance_checker #(
	parameter int unsigned STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] char_byte
	input  logic       s_axis_tlast,   // last_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata    // [0] balanced, [1] overflowed, [7:2] zero
);
	import bbc_pkg::*;

	stack_cmd_t  cmd;
	stack_stat_t stat;
	bracket_t    opn;
	bracket_t    cls;
	logic        acc;
	logic        err_q;
	logic        ovf_q;
	logic        err_n;
	logic        ovf_n;
	logic        empty_after;
	logic        out_valid_q;
	logic [1:0]  out_data_q;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign acc = s_axis_tvalid && s_axis_tready;

	assign opn = decode_open(s_axis_tdata);
	assign cls = decode_close(s_axis_tdata);

	assign cmd.push  = acc && opn.hit && !stat.full;
	assign cmd.pop   = acc && cls.hit && !stat.empty && (stat.top == cls.code);
	assign cmd.clear = acc && s_axis_tlast;
	assign cmd.code  = opn.code;

	bbc_stack #(
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.stat  (stat)
	);

	assign err_n = err_q || (acc && cls.hit && !cmd.pop);
	assign ovf_n = ovf_q || (acc && opn.hit && stat.full);
	assign empty_after = cmd.push ? 1'b0 : (cmd.pop ? stat.single : stat.empty);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q       <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				err_q <= 1'b0;
				ovf_q <= 1'b0;
			end else begin
				err_q <= err_n;
				ovf_q <= ovf_n;
			end
			if (cmd.clear) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			out_data_q <= {ovf_n, !err_n && !ovf_n && empty_after};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_data_q};

endmodule

// ===== dv/bracket_balance_checker_tb.sv =====
module bracket_balance_checker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bbc_pkg::*;

	localparam int unsigned DEPTH = STACK_DEPTH_DEF;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_PCT = 36;

	typedef struct packed {
		logic balanced;
		logic overflowed;
	} verdict_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;  // [7:0] char_byte
	logic       s_axis_tlast = 1'b0;   // last_byte
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;          // [0] balanced, [1] overflowed, [7:2] zero

	verdict_t    verdict_q[$];
	code_t       open_stack[DEPTH];
	int unsigned open_depth = 0;
	bit          mismatch_seen = 1'b0;
	bit          depth_exceeded = 1'b0;

	bit steady = 1'b0;
	bit stall_request = 1'b0;
	int stall_left = 0;
	int quiet_cycles = 0;
	int fail_count = 0;
	int words_sent = 0;

	bracket_balance_checker #(.STACK_DEPTH(DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [7:0] open_char(input code_t k);
		case (k)
			CODE_SQUARE: return CHR_LSQUARE;
			CODE_CURLY:  return CHR_LCURLY;
			default:     return CHR_LPAREN;
		endcase
	endfunction

	function automatic logic [7:0] close_char(input code_t k);
		case (k)
			CODE_SQUARE: return CHR_RSQUARE;
			CODE_CURLY:  return CHR_RCURLY;
			default:     return CHR_RPAREN;
		endcase
	endfunction

	function automatic code_t random_kind();
		return code_t'($urandom_range(2));
	endfunction

	function automatic void track_word(input logic [7:0] c, input logic l);
		code_t kind;
		bit is_open;
		bit is_close;
		kind = CODE_PAREN;
		is_open = 1'b0;
		is_close = 1'b0;
		case (c)
			CHR_LPAREN:  begin is_open = 1'b1; kind = CODE_PAREN; end
			CHR_LSQUARE: begin is_open = 1'b1; kind = CODE_SQUARE; end
			CHR_LCURLY:  begin is_open = 1'b1; kind = CODE_CURLY; end
			CHR_RPAREN:  begin is_close = 1'b1; kind = CODE_PAREN; end
			CHR_RSQUARE: begin is_close = 1'b1; kind = CODE_SQUARE; end
			CHR_RCURLY:  begin is_close = 1'b1; kind = CODE_CURLY; end
			default:     ;
		endcase
		if (is_open) begin
			if (open_depth < DEPTH) begin
				open_stack[open_depth] = kind;
				open_depth++;
			end else begin
				depth_exceeded = 1'b1;
			end
		end else if (is_close) begin
			if (open_depth == 0 || open_stack[open_depth - 1] != kind)
				mismatch_seen = 1'b1;
			else
				open_depth--;
		end
		if (l) begin
			verdict_q.push_back('{
				balanced: !mismatch_seen && !depth_exceeded && open_depth == 0,
				overflowed: depth_exceeded
			});
			open_depth = 0;
			mismatch_seen = 1'b0;
			depth_exceeded = 1'b0;
		end
	endfunction

	task automatic send_word(input logic [7:0] c, input logic l);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tlast <= l;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		track_word(c, l);
		words_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i], i == s.len() - 1);
	endtask

	task automatic send_random_expression(input int pairs, input bit deep);
		logic [7:0] body[$];
		code_t pending[$];
		code_t kind;
		int opens_left;
		int pos;
		opens_left = pairs;
		while (opens_left > 0 || pending.size() > 0) begin
			if ($urandom_range(99) < 15)
				body.push_back(8'($urandom_range(255)));
			if (opens_left > 0 && (pending.size() == 0 || deep || $urandom_range(1))) begin
				kind = random_kind();
				pending.push_back(kind);
				body.push_back(open_char(kind));
				opens_left--;
			end else begin
				body.push_back(close_char(pending.pop_back()));
			end
		end
		// break about one in five
		if ($urandom_range(99) < 20) begin
			case ($urandom_range(2))
				0: begin
					if (body.size() > 0) begin
						pos = $urandom_range(body.size() - 1);
						body[pos] = $urandom_range(1) ? open_char(random_kind())
							: close_char(random_kind());
					end
				end
				1: if (body.size() > 1) void'(body.pop_back());
				default: body.push_front(close_char(random_kind()));
			endcase
		end
		if (body.size() == 0)
			body.push_back(8'($urandom_range(255)));
		foreach (body[i])
			send_word(body[i], i == body.size() - 1);
	endtask

	task automatic test_directed();
		send_word(8'h00, 1'b1);
		send_word(8'hFF, 1'b1);
		send_text("()");
		send_text("([{}])");
		send_text("(]");
		send_text(")()");
		send_text("a(");
		send_text("{x}");
		send_text("[)]");
	endtask

	task automatic test_stack_limits();
		for (int i = 0; i < DEPTH; i++)
			send_word(open_char(code_t'(i % 3)), 1'b0);
		for (int i = DEPTH - 1; i >= 0; i--)
			send_word(close_char(code_t'(i % 3)), i == 0);
		for (int i = 0; i <= DEPTH; i++)
			send_word(CHR_LPAREN, 1'b0);
		for (int i = 0; i < DEPTH; i++)
			send_word(CHR_RPAREN, i == DEPTH - 1);
		for (int i = 0; i < DEPTH; i++)
			send_word(CHR_LCURLY, 1'b0);
		send_word(CHR_LSQUARE, 1'b1);
	endtask

	task automatic test_back_pressure();
		stall_request = 1'b1;
		for (int i = 0; i < 40; i++) begin
			case (i % 3)
				0: send_text("()");
				1: send_text("(]");
				default: send_word(8'($urandom_range(255)), 1'b1);
			endcase
		end
	endtask

	task automatic test_streaming(input int count, input bit no_gaps);
		int stop_at;
		int r;
		stop_at = words_sent + count;
		steady = no_gaps;
		while (words_sent < stop_at) begin
			r = $urandom_range(99);
			if (r < 3)
				send_random_expression($urandom_range(60, 70), 1'b1);
			else if (r < 10)
				send_random_expression(0, 1'b0);
			else
				send_random_expression($urandom_range(1, 10), 1'b0);
		end
		steady = 1'b0;
	endtask

	always @(posedge clk) begin
		if (stall_request) begin
			stall_request = 1'b0;
			stall_left = HOLD_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin : result_check
		verdict_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (verdict_q.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected word, expected none actual %h", $time, m_axis_tdata);
			end else begin
				want = verdict_q.pop_front();
				if (m_axis_tdata[0] !== want.balanced) begin
					fail_count++;
					if (fail_count <= 100)
						$display("%0t: balanced expected %0b actual %0b",
							$time, want.balanced, m_axis_tdata[0]);
				end
				if (m_axis_tdata[1] !== want.overflowed) begin
					fail_count++;
					if (fail_count <= 100)
						$display("%0t: overflowed expected %0b actual %0b",
							$time, want.overflowed, m_axis_tdata[1]);
				end
				if (m_axis_tdata[7:2] !== 6'd0) begin
					fail_count++;
					if (fail_count <= 100)
						$display("%0t: pad bits expected 0 actual %b",
							$time, m_axis_tdata[7:2]);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_stack_limits();
		test_back_pressure();
		test_streaming(150, 1'b1);
		test_streaming(290, 1'b0);
		s_axis_tvalid <= 1'b0;
		while (verdict_q.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/bbc_pkg.sv
design/bbc_stack.sv
design/bracket_balance_checker.sv
dv/bracket_balance_checker_tb.sv
